>>> design/mpsa_pkg.sv
package mpsa_pkg;

  localparam int W = 63;
  localparam int CNT_W = $clog2(W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(W - 1);

  typedef logic [W-1:0] word_t;

  // function codes
  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd1;
  localparam logic [2:0] FN_NEG = 3'd2;
  localparam logic [2:0] FN_MUL = 3'd3;
  localparam logic [2:0] FN_INV = 3'd4;
  localparam logic [2:0] FN_POW = 3'd5;

  localparam word_t MOD_RESET = {2'b00, {(W - 2){1'b1}}};
  localparam word_t ONE = W'(1);

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL_GO,
    S_MUL_WAIT,
    S_POW_TEST,
    S_POW_MR,
    S_POW_MRW,
    S_POW_MS,
    S_POW_MSW,
    S_INV_TEST,
    S_INV_DIV,
    S_INV_DIVW,
    S_INV_MUL,
    S_INV_MULW,
    S_DONE
  } state_t;

  // a + b mod p, both below p
  function automatic word_t add_mod(word_t a, word_t b, word_t p);
    logic [W:0]   s;
    logic [W+1:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = {1'b0, s} - {2'b00, p};
    return d[W+1] ? s[W-1:0] : d[W-1:0];
  endfunction

  // a - b mod p, both below p
  function automatic word_t sub_mod(word_t a, word_t b, word_t p);
    logic [W:0] d;
    d = {1'b0, a} - {1'b0, b};
    return d[W] ? W'(d[W-1:0] + p) : d[W-1:0];
  endfunction

endpackage

>>> design/mpsa_ifs.sv
interface mpsa_req_if import mpsa_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] func;
  word_t      operand_a;
  word_t      operand_b;
  modport source(output valid, func, operand_a, operand_b, input ready);
  modport sink(input valid, func, operand_a, operand_b, output ready);
endinterface

interface mpsa_rsp_if import mpsa_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t result;
  logic  no_inverse;
  logic  range_error;
  modport source(output valid, result, no_inverse, range_error, input ready);
  modport sink(input valid, result, no_inverse, range_error, output ready);
endinterface

interface mpsa_cfg_if import mpsa_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t modulus;
  modport source(output valid, modulus, input ready);
  modport sink(input valid, modulus, output ready);
endinterface

>>> design/mpsa_mulmod.sv
module mpsa_mulmod import mpsa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  word_t     op_a,
  input  word_t     op_b,
  input  word_t     modulus,
  output unit_sts_t sts,
  output word_t     prod
);

  logic             busy;
  logic             done;
  logic             phase;
  logic [CNT_W-1:0] cnt;
  word_t            a_l;
  word_t            b_sh;
  word_t            acc;
  word_t            addend;
  word_t            acc_next;
  logic             advance;

  // phase 0 doubles, phase 1 adds the multiplicand
  assign addend   = phase ? a_l : acc;
  assign acc_next = add_mod(acc, addend, modulus);
  assign advance  = phase || !b_sh[W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
      end else if (busy) begin
        if (advance) begin
          phase <= 1'b0;
          if (cnt == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end else begin
          phase <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      a_l  <= op_a;
      b_sh <= op_b;
      cnt  <= LAST_STEP;
    end else if (busy) begin
      acc <= acc_next;
      if (advance) begin
        b_sh <= {b_sh[W-2:0], 1'b0};
        cnt  <= cnt - 1'b1;
      end
    end
  end

  assign sts  = '{busy: busy, done: done};
  assign prod = acc;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("mulmod started while busy");

endmodule

>>> design/mpsa_divu.sv
module mpsa_divu import mpsa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  word_t     dividend,
  input  word_t     divisor,
  output unit_sts_t sts,
  output word_t     quot,
  output word_t     rem
);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  word_t            d_l;
  word_t            q_sh;
  word_t            r;
  logic [W:0]       t;
  logic [W:0]       diff;
  logic             ge;

  // restoring division, one quotient bit per cycle
  assign t    = {r, q_sh[W-1]};
  assign diff = t - {1'b0, d_l};
  assign ge   = (t >= {1'b0, d_l});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_l  <= divisor;
      q_sh <= dividend;
      r    <= '0;
      cnt  <= LAST_STEP;
    end else if (busy) begin
      q_sh <= {q_sh[W-2:0], ge};
      r    <= ge ? diff[W-1:0] : t[W-1:0];
      cnt  <= cnt - 1'b1;
    end
  end

  assign sts  = '{busy: busy, done: done};
  assign quot = q_sh;
  assign rem  = r;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");

endmodule

>>> design/mod_p_scalar_alu.sv
// channel | dir | beat contents
// cfg     | in  | modulus
// req     | in  | func, operand_a, operand_b
// rsp     | out | result, no_inverse, range_error
//
// add, sub, negate and range failures go from idle through decode to done and then to the output register
// multiply runs the shared mod-multiplier: one doubling per bit of operand b, plus an add of a for each set bit
// power: up to 63 exponent bits, each one or two multiplies
// inverse: per euclid step one divide and one multiply, up to about 90 steps
// req is ready only in idle; a stalled rsp beat holds the next result in the done state
// rst clears control and loads modulus with 2^61 - 1
module mod_p_scalar_alu import mpsa_pkg::*; (
  input logic        clk,
  input logic        rst,
  mpsa_cfg_if.sink   cfg,
  mpsa_req_if.sink   req,
  mpsa_rsp_if.source rsp
);

  state_t    state;
  state_t    state_next;
  word_t     modulus;
  logic [2:0] op;
  word_t     x;          // operand a / euclid remainder
  word_t     y;          // operand b, exponent, euclid divisor
  word_t     cx;         // power accumulator / coefficient
  word_t     cy;         // power base / next coefficient
  word_t     qm;         // quotient reduced mod p
  word_t     res;
  logic      noinv;
  logic      rerr;

  logic      rsp_valid;
  word_t     rsp_result;
  logic      rsp_noinv;
  logic      rsp_rerr;

  logic      mul_start;
  word_t     mul_a;
  word_t     mul_b;
  unit_sts_t mul_sts;
  word_t     mul_p;
  logic      div_start;
  unit_sts_t div_sts;
  word_t     div_q;
  word_t     div_r;

  logic      need_b;
  logic      bad;
  logic      out_free;

  // modulus register, written only while idle
  assign cfg.ready = (state == S_IDLE);
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_RESET;
    end else if (cfg.valid && cfg.ready) begin
      modulus <= cfg.modulus;
    end
  end

  assign need_b   = (op == FN_ADD) || (op == FN_SUB) || (op == FN_MUL);
  assign bad      = (modulus < W'(2)) || (x >= modulus) || (need_b && (y >= modulus));
  assign out_free = !rsp_valid || rsp.ready;

  mpsa_mulmod u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .modulus (modulus),
    .sts     (mul_sts),
    .prod    (mul_p)
  );

  mpsa_divu u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (x),
    .divisor  (y),
    .sts      (div_sts),
    .quot     (div_q),
    .rem      (div_r)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (req.valid) state_next = S_DECODE;
      S_DECODE: begin
        if (op > FN_POW || bad) state_next = S_DONE;
        else if (op == FN_MUL) state_next = S_MUL_GO;
        else if (op == FN_POW) state_next = S_POW_TEST;
        else if (op == FN_INV) state_next = S_INV_TEST;
        else state_next = S_DONE;
      end
      S_MUL_GO:   state_next = S_MUL_WAIT;
      S_MUL_WAIT: if (mul_sts.done) state_next = S_DONE;
      S_POW_TEST: begin
        if (y == '0) state_next = S_DONE;
        else if (y[0]) state_next = S_POW_MR;
        else state_next = S_POW_MS;
      end
      S_POW_MR:   state_next = S_POW_MRW;
      S_POW_MRW:  if (mul_sts.done) state_next = S_POW_MS;
      S_POW_MS:   state_next = S_POW_MSW;
      S_POW_MSW:  if (mul_sts.done) state_next = S_POW_TEST;
      S_INV_TEST: state_next = (y == '0) ? S_DONE : S_INV_DIV;
      S_INV_DIV:  state_next = S_INV_DIVW;
      S_INV_DIVW: if (div_sts.done) state_next = S_INV_MUL;
      S_INV_MUL:  state_next = S_INV_MULW;
      S_INV_MULW: if (mul_sts.done) state_next = S_INV_TEST;
      S_DONE:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    req.ready = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = x;
    mul_b     = y;
    case (state)
      S_IDLE:   req.ready = 1'b1;
      S_MUL_GO: mul_start = 1'b1;
      S_POW_MR: begin
        mul_start = 1'b1;
        mul_a     = cx;
        mul_b     = cy;
      end
      S_POW_MS: begin
        mul_start = 1'b1;
        mul_a     = cy;
        mul_b     = cy;
      end
      S_INV_DIV: div_start = 1'b1;
      S_INV_MUL: begin
        mul_start = 1'b1;
        mul_a     = qm;
        mul_b     = cy;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op    <= req.func;
        x     <= req.operand_a;
        y     <= req.operand_b;
        res   <= '0;
        noinv <= 1'b0;
        rerr  <= 1'b0;
      end
      S_DECODE: begin
        if (op <= FN_POW && bad) begin
          rerr <= 1'b1;
        end else begin
          case (op)
            FN_ADD: res <= add_mod(x, y, modulus);
            FN_SUB: res <= sub_mod(x, y, modulus);
            FN_NEG: res <= (x == '0) ? '0 : W'(modulus - x);
            FN_INV: begin
              cx <= ONE;
              cy <= '0;
              y  <= modulus;
            end
            FN_POW: begin
              cx <= ONE;
              cy <= x;
            end
            default: res <= '0;
          endcase
        end
      end
      S_MUL_WAIT: if (mul_sts.done) res <= mul_p;
      S_POW_TEST: if (y == '0) res <= cx;
      S_POW_MRW:  if (mul_sts.done) cx <= mul_p;
      S_POW_MSW: begin
        if (mul_sts.done) begin
          cy <= mul_p;
          y  <= {1'b0, y[W-1:1]};
        end
      end
      S_INV_TEST: begin
        if (y == '0) begin
          if (x == ONE) begin
            res <= cx;
          end else begin
            noinv <= 1'b1;
          end
        end
      end
      // quotient never exceeds p, one subtract reduces it
      S_INV_DIVW: if (div_sts.done) qm <= (div_q >= modulus) ? W'(div_q - modulus) : div_q;
      S_INV_MULW: begin
        if (mul_sts.done) begin
          x  <= y;
          y  <= div_r;
          cx <= cy;
          cy <= sub_mod(cx, mul_p, modulus);
        end
      end
      default: begin
        res <= res;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      rsp_result <= res;
      rsp_noinv  <= noinv;
      rsp_rerr   <= rerr;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.result      = rsp_result;
  assign rsp.no_inverse  = rsp_noinv;
  assign rsp.range_error = rsp_rerr;

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_noinv |-> !rsp_rerr && rsp_result == '0)
    else $error("no_inverse beat with range flag or nonzero result");

  // a stalled result beat stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ready |=> rsp_valid && $stable(rsp_result) &&
      $stable(rsp_noinv) && $stable(rsp_rerr))
    else $error("result beat changed while stalled");

  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg.valid && cfg.ready |-> state == S_IDLE)
    else $error("modulus written while busy");

endmodule
